// ===== hw/rtl/gccb_pkg.sv =====
// Shared types, register indexes, divide-by-255 helper and square-root ROM for the blend core.
package gccb_pkg;

    typedef enum logic [1:0] {
        CFG_FG_COLOR   = 2'd0,
        CFG_GAMMA_MODE = 2'd1,
        CFG_DRAW_WIDTH = 2'd2
    } t_cfg_reg;

    localparam int CHANNELS = 3;
    localparam logic [7:0] FULL_COVERAGE = 8'hFF;

    typedef logic [7:0]  t_chan;
    typedef logic [15:0] t_wide;
    typedef t_chan [255:0] t_rom;

    // floor(x / 255) for x <= 255*255
    function automatic t_chan div255(input t_wide x);
        logic [16:0] sum;
        sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

    // entry i holds round(sqrt(i * 255))
    function automatic t_rom build_root_rom();
        t_rom rom;
        int   x;
        int   r;
        for (int i = 0; i < 256; i++) begin
            x = i * 255;
            r = 0;
            for (int v = 0; v < 256; v++) begin
                if ((2 * v + 1) * (2 * v + 1) <= 4 * x) begin
                    r = v + 1;
                end
            end
            rom[i] = r[7:0];
        end
        return rom;
    endfunction

    localparam t_rom ROOT_ROM = build_root_rom();

endpackage

// ===== hw/rtl/gamma_correct_coverage_blend_core.sv =====
// Top level of the coverage blend core: config registers and five-stage blend pipeline.
// Blends one glyph coverage value over one background pixel with the foreground color
// in fg_color, per R/G/B channel, either in linear light (square/255, mix, sqrt ROM) or
// on raw bytes. Each pixel passes five register stages (square, linearize, weight, mix,
// output) between its input transfer and its result; the pipeline accepts one pixel
// per clock, and a stall on the output holds each stage that is full.
// Pixels whose column is negative, at or beyond draw_width, or with zero coverage come
// out unchanged with write_enable low. Configuration writes are always accepted and take
// effect at once; write them only while the pipeline is empty.
module gamma_correct_coverage_blend_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_coverage,
    input  logic [31:0]        i_background,
    input  logic signed [12:0] i_pixel_column,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_pixel_out,
    output logic               o_write_enable
);

    localparam int NCH = gccb_pkg::CHANNELS;

    logic [23:0] r_fg;
    logic        r_gamma;
    logic [12:0] r_width;

    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    logic        en1, en2, en3, en4, en5;

    logic [7:0]  r_cov1, r_cov2;
    logic [31:0] r_bg1, r_bg2, r_bg3, r_bg4;
    logic        r_we1, r_we2, r_we3, r_we4;
    logic        r_full1, r_full2, r_full3, r_full4;
    gccb_pkg::t_wide r_sqf1 [NCH];
    gccb_pkg::t_wide r_sqb1 [NCH];
    gccb_pkg::t_chan r_lf2 [NCH];
    gccb_pkg::t_chan r_lb2 [NCH];
    gccb_pkg::t_wide r_pf3 [NCH];
    gccb_pkg::t_wide r_pb3 [NCH];
    gccb_pkg::t_chan r_m4 [NCH];
    logic [31:0] r_pix5;
    logic        r_we5;

    gccb_pkg::t_chan fg_ch [NCH];
    gccb_pkg::t_chan bg_ch [NCH];
    gccb_pkg::t_chan bg1_ch [NCH];
    gccb_pkg::t_chan n_out_ch [NCH];
    logic        n_we;
    logic [31:0] n_pix;
    logic [7:0]  inv_cov;
    gccb_pkg::t_wide mix_sum [NCH];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg    <= 24'hFFFFFF;
            r_gamma <= 1'b1;
            r_width <= 13'd1920;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gccb_pkg::CFG_FG_COLOR:   r_fg    <= i_cfg_data;
                gccb_pkg::CFG_GAMMA_MODE: r_gamma <= i_cfg_data[0];
                gccb_pkg::CFG_DRAW_WIDTH: r_width <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or its successor advances
    assign en5 = !r_v5 || i_out_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_ready  = en1;
    assign o_out_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            fg_ch[c]  = r_fg[8*c +: 8];
            bg_ch[c]  = i_background[8*c +: 8];
            bg1_ch[c] = r_bg1[8*c +: 8];
        end
    end

    assign n_we = !i_pixel_column[12] && ($unsigned(i_pixel_column) < r_width)
                  && (i_coverage != 8'd0);
    assign inv_cov = 8'hFF - r_cov2;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_cov1  <= i_coverage;
            r_bg1   <= i_background;
            r_we1   <= n_we;
            r_full1 <= (i_coverage == gccb_pkg::FULL_COVERAGE);
            for (int c = 0; c < NCH; c++) begin
                r_sqf1[c] <= {8'd0, fg_ch[c]} * {8'd0, fg_ch[c]};
                r_sqb1[c] <= {8'd0, bg_ch[c]} * {8'd0, bg_ch[c]};
            end
        end
        if (en2) begin
            r_cov2  <= r_cov1;
            r_bg2   <= r_bg1;
            r_we2   <= r_we1;
            r_full2 <= r_full1;
            for (int c = 0; c < NCH; c++) begin
                r_lf2[c] <= r_gamma ? gccb_pkg::div255(r_sqf1[c]) : fg_ch[c];
                r_lb2[c] <= r_gamma ? gccb_pkg::div255(r_sqb1[c]) : bg1_ch[c];
            end
        end
        if (en3) begin
            r_bg3   <= r_bg2;
            r_we3   <= r_we2;
            r_full3 <= r_full2;
            for (int c = 0; c < NCH; c++) begin
                r_pf3[c] <= {8'd0, r_cov2} * {8'd0, r_lf2[c]};
                r_pb3[c] <= {8'd0, inv_cov} * {8'd0, r_lb2[c]};
            end
        end
        if (en4) begin
            r_bg4   <= r_bg3;
            r_we4   <= r_we3;
            r_full4 <= r_full3;
            for (int c = 0; c < NCH; c++) begin
                r_m4[c] <= gccb_pkg::div255(mix_sum[c]);
            end
        end
        if (en5) begin
            r_pix5 <= n_pix;
            r_we5  <= r_we4;
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            mix_sum[c]  = r_pf3[c] + r_pb3[c];
            n_out_ch[c] = r_gamma ? gccb_pkg::ROOT_ROM[r_m4[c]] : r_m4[c];
        end
        if (!r_we4) begin
            n_pix = r_bg4;
        end else if (r_full4) begin
            n_pix = {8'h00, r_fg};
        end else begin
            n_pix = {8'h00, n_out_ch[2], n_out_ch[1], n_out_ch[0]};
        end
    end

    assign o_pixel_out    = r_pix5;
    assign o_write_enable = r_we5;

endmodule

// ===== bench/blend_checker.sv =====
// Checker for the coverage blend core: predicts each pixel and compares it at the output.
module blend_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_coverage,
    input  logic [31:0]        i_background,
    input  logic signed [12:0] i_pixel_column,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [31:0]        i_pixel_out,
    input  logic               i_write_enable,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [31:0] pixel;
        logic        wr;
    } t_pixel_result;

    t_pixel_result expected_pixels[$];
    logic [23:0]   fg_color;
    logic          gamma_on;
    logic [12:0]   draw_width;
    int            fails;

    function automatic logic [7:0] nearest_root(int x);
        int v;
        v = 0;
        while ((v + 1) * (v + 1) <= x) v++;
        if (x - v * v > v) v++;
        return 8'(v);
    endfunction

    function automatic logic [7:0] blend_channel(int a, int f, int b);
        int lin_f;
        int lin_b;
        int mixed;
        if (gamma_on) begin
            lin_f = (f * f) / 255;
            lin_b = (b * b) / 255;
            mixed = (a * lin_f + (255 - a) * lin_b) / 255;
            return nearest_root(mixed * 255);
        end
        return 8'((a * f + (255 - a) * b) / 255);
    endfunction

    function automatic t_pixel_result blend_pixel(logic [7:0] cov, logic [31:0] bg,
                                                  logic [12:0] col);
        t_pixel_result res;
        res.pixel = bg;
        res.wr    = 1'b0;
        if (!col[12] && col < draw_width && cov != 8'd0) begin
            res.wr = 1'b1;
            if (cov == gccb_pkg::FULL_COVERAGE) begin
                res.pixel = {8'h00, fg_color};
            end else begin
                res.pixel = {8'h00,
                             blend_channel(cov, fg_color[23:16], bg[23:16]),
                             blend_channel(cov, fg_color[15:8], bg[15:8]),
                             blend_channel(cov, fg_color[7:0], bg[7:0])};
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            fg_color   <= 24'hFFFFFF;
            gamma_on   <= 1'b1;
            draw_width <= 13'd1920;
            expected_pixels.delete();
            fails = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel_out: no transfer expected, got %h", i_pixel_out);
                    fails++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel_out !== want.pixel) begin
                        $error("pixel_out: expected %h, got %h", want.pixel, i_pixel_out);
                        fails++;
                    end
                    if (i_write_enable !== want.wr) begin
                        $error("write_enable: expected %0b, got %0b", want.wr, i_write_enable);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_pixels.push_back(blend_pixel(i_coverage, i_background,
                                                      i_pixel_column));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (gccb_pkg::t_cfg_reg'(i_cfg_index))
                    gccb_pkg::CFG_FG_COLOR: begin
                        fg_color <= i_cfg_data;
                    end
                    gccb_pkg::CFG_GAMMA_MODE: begin
                        gamma_on <= i_cfg_data[0];
                    end
                    gccb_pkg::CFG_DRAW_WIDTH: begin
                        draw_width <= i_cfg_data[12:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fails;
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the coverage blend core: clock, reset, stimulus, stalls and verdict.
module tb;

    localparam int QUIET_LIMIT = 4000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [23:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_coverage;
    logic [31:0]        i_background;
    logic signed [12:0] i_pixel_column;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [31:0]        o_pixel_out;
    logic               o_write_enable;

    int fail_count;
    int pending_results;
    int sender_idle_pct;
    int receiver_idle_pct;
    int active_width;
    int quiet_cycles;

    gamma_correct_coverage_blend_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_coverage     (i_coverage),
        .i_background   (i_background),
        .i_pixel_column (i_pixel_column),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_out    (o_pixel_out),
        .o_write_enable (o_write_enable)
    );

    blend_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_coverage     (i_coverage),
        .i_background   (i_background),
        .i_pixel_column (i_pixel_column),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_pixel_out    (o_pixel_out),
        .i_write_enable (o_write_enable),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready)
            || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input gccb_pkg::t_cfg_reg idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic [23:0] fg, input logic gm, input logic [12:0] width);
        write_reg(gccb_pkg::CFG_FG_COLOR, fg);
        write_reg(gccb_pkg::CFG_GAMMA_MODE, {23'd0, gm});
        write_reg(gccb_pkg::CFG_DRAW_WIDTH, {11'd0, width});
        i_cfg_valid  <= 1'b0;
        active_width = width;
    endtask

    task automatic send_pixel(input logic [7:0] cov, input logic [31:0] bg,
                              input logic signed [12:0] col);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_coverage     <= cov;
        i_background   <= bg;
        i_pixel_column <= col;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_empty();
        i_in_valid <= 1'b0;
        while (pending_results != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_pixel(8'd0,   32'hFFFFFFFF, 13'sd0);
        send_pixel(8'd255, 32'hA5000000, 13'sd0);
        send_pixel(8'd1,   32'hFF000000, 13'sd5);
        send_pixel(8'd254, 32'hFFFFFFFF, 13'sd100);
        send_pixel(8'd128, 32'h00808080, 13'sd1919);
        send_pixel(8'd128, 32'h00808080, 13'sd1920);
        send_pixel(8'd200, 32'h7F10E0C3, 13'sd4095);
        send_pixel(8'd200, 32'h7F10E0C3, -13'sd1);
        send_pixel(8'd200, 32'h7F10E0C3, -13'sd4096);
        send_pixel(8'd255, 32'h00000000, -13'sd4096);
        send_pixel(8'd64,  32'h5A3C96F0, 13'sd0);
        send_pixel(8'd255, 32'hFFFFFFFF, 13'sd4095);
    endtask

    function automatic logic [7:0] pick_coverage();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 8'd0;
        if (r < 16) return gccb_pkg::FULL_COVERAGE;
        if (r < 22) return ($urandom_range(1) != 0) ? 8'd1 : 8'd254;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic signed [12:0] pick_column(int width);
        int r;
        r = $urandom_range(99);
        if (width > 0 && r < 75) return 13'($urandom_range(width - 1));
        if (r < 85) return 13'(-int'($urandom_range(4096, 1)));
        return 13'($urandom);
    endfunction

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_index       <= gccb_pkg::CFG_FG_COLOR;
        i_cfg_data        <= 24'd0;
        i_in_valid        <= 1'b0;
        i_coverage        <= 8'd0;
        i_background      <= 32'd0;
        i_pixel_column    <= 13'sd0;
        receiver_idle_pct <= 68;
        sender_idle_pct   = 7;
        active_width      = 1920;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        wait_empty();
        configure(24'h00FF00, 1'b0, 13'd4096);
        run_directed();

        for (int p = 0; p < 9; p++) begin
            wait_empty();
            if (p < 3) begin
                sender_idle_pct   = 7;
                receiver_idle_pct <= 68;
            end else if (p < 6) begin
                sender_idle_pct   = 68;
                receiver_idle_pct <= 7;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct <= 0;
            end
            case (p)
                0: configure(24'h000000, 1'b1, 13'd4096);
                1: configure(24'hFFFFFF, 1'b0, 13'd0);
                2: configure(24'($urandom), 1'b0, 13'd4096);
                3: configure(24'($urandom), 1'b1, 13'd1);
                4: configure(24'($urandom), 1'b1, 13'($urandom_range(4096)));
                5: configure(24'hFFFFFF, 1'b0, 13'd4095);
                6: configure(24'($urandom), 1'b1, 13'd4096);
                7: configure(24'h000000, 1'b0, 13'($urandom_range(4096)));
                default: configure(24'($urandom), 1'($urandom), 13'd1920);
            endcase
            for (int n = 0; n < 86; n++) begin
                send_pixel(pick_coverage(), $urandom, pick_column(active_width));
            end
        end

        wait_empty();
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
